@@ rtl/assert_macros.svh @@
// Assertion macros used by the line position estimator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/lpce_pkg.sv @@
// Package with types and constants for the line position estimator.
`timescale 1ns / 1ps
package lpce_pkg;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int FILTER_SHIFT_DEF = 1;
    localparam int NUM_CH     = 4;
    localparam int LEVEL_W    = 10;
    localparam int STRENGTH_W = 12;
    localparam int ERROR_W    = 13;
    localparam int WEIGHT_W   = 23;
    localparam int QUOT_W     = 12;
    localparam int LEVEL_MAX  = 1000;
    localparam int WEIGHT_OUTER = 3000;
    localparam int WEIGHT_INNER = 1000;

    localparam logic [63:0] WHITE_RST = 64'd27490727772340;
    localparam logic [63:0] BLACK_RST = 64'd138855635397250;
    localparam logic [STRENGTH_W-1:0] THRESH_RST  = 12'd80;
    localparam logic [STRENGTH_W-1:0] LOST_MAG_RST = 12'd3000;

    typedef enum logic [1:0] {
        REG_WHITE     = 2'd0,
        REG_BLACK     = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_LOST_MAG  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_LANES, ST_MERGE, ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        LN_IDLE, LN_MUL, LN_CMP, LN_DIV
    } lane_state_t;

    typedef enum logic [1:0] {
        MG_IDLE, MG_DIV, MG_FIN
    } merge_state_t;
endpackage

@@ rtl/lpce_lane.sv @@
// One channel lane: low-pass filter and per-mille normalization with a serial divider.
`timescale 1ns / 1ps
module lpce_lane #(
    parameter int SAMPLE_BITS  = lpce_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_SHIFT = lpce_pkg::FILTER_SHIFT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          primed,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic [SAMPLE_BITS-1:0]        white,
    input  logic [SAMPLE_BITS-1:0]        black,
    output logic                          busy,
    output logic [SAMPLE_BITS-1:0]        filtered,
    output logic [lpce_pkg::LEVEL_W-1:0]  level
);
    localparam int ACC_W = SAMPLE_BITS + FILTER_SHIFT;
    localparam int NUM_W = SAMPLE_BITS + lpce_pkg::LEVEL_W;
    localparam int LW    = lpce_pkg::LEVEL_W;

    lpce_pkg::lane_state_t state_reg, state_next;
    logic [ACC_W-1:0]       acc_reg;
    logic [SAMPLE_BITS-1:0] filt_reg;
    logic [NUM_W-1:0]       num_reg, dden_reg, rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic                   zero_reg;
    logic [LW-1:0]          q_reg, q_next, level_reg, level_next;
    logic [3:0]             bit_reg, bit_next;

    logic [ACC_W-1:0]         target, acc_new;
    logic signed [ACC_W+1:0]  diff, step, acc_sum;
    logic [ACC_W:0]           rnd;
    logic [SAMPLE_BITS:0]     filt_full;
    logic [SAMPLE_BITS-1:0]   filt_new, mag, den;
    logic [NUM_W-1:0]         trial;

    // The arithmetic shift of the difference floors toward minus infinity.
    always_comb begin
        target    = {sample, {FILTER_SHIFT{1'b0}}};
        diff      = $signed({2'b00, target}) - $signed({2'b00, acc_reg});
        step      = diff >>> FILTER_SHIFT;
        acc_sum   = $signed({2'b00, acc_reg}) + step;
        acc_new   = primed ? acc_sum[ACC_W-1:0] : target;
        rnd       = {1'b0, acc_new} + ((ACC_W+1)'(1) << (FILTER_SHIFT - 1));
        filt_full = rnd[ACC_W:FILTER_SHIFT];
        filt_new  = filt_full[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}} : filt_full[SAMPLE_BITS-1:0];
    end

    // An inverted span is handled as the mirrored positive case.
    always_comb begin
        if (black >= white) begin
            den = black - white;
            mag = (filt_reg > white) ? filt_reg - white : '0;
        end else begin
            den = white - black;
            mag = (filt_reg < white) ? white - filt_reg : '0;
        end
    end

    assign trial = NUM_W'(den_reg) << bit_reg;

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        level_next = level_reg;
        case (state_reg)
            lpce_pkg::LN_IDLE: begin
                if (start) begin
                    state_next = lpce_pkg::LN_MUL;
                end
            end
            lpce_pkg::LN_MUL: begin
                state_next = lpce_pkg::LN_CMP;
            end
            lpce_pkg::LN_CMP: begin
                if (zero_reg) begin
                    level_next = '0;
                    state_next = lpce_pkg::LN_IDLE;
                end else if (num_reg >= dden_reg) begin
                    level_next = LW'(lpce_pkg::LEVEL_MAX);
                    state_next = lpce_pkg::LN_IDLE;
                end else begin
                    rem_next   = num_reg;
                    q_next     = '0;
                    bit_next   = 4'(LW - 1);
                    state_next = lpce_pkg::LN_DIV;
                end
            end
            lpce_pkg::LN_DIV: begin
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    q_next   = q_reg | (LW'(1) << bit_reg);
                end
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0) begin
                    level_next = (rem_reg >= trial) ? (q_reg | LW'(1)) : q_reg;
                    state_next = lpce_pkg::LN_IDLE;
                end
            end
            default: begin
                state_next = lpce_pkg::LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpce_pkg::LN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lpce_pkg::LN_IDLE && start) begin
            acc_reg  <= acc_new;
            filt_reg <= filt_new;
        end
        if (state_reg == lpce_pkg::LN_MUL) begin
            den_reg  <= den;
            zero_reg <= (den == '0);
            num_reg  <= NUM_W'(mag) * NUM_W'(lpce_pkg::LEVEL_MAX);
            dden_reg <= NUM_W'(den) * NUM_W'(lpce_pkg::LEVEL_MAX);
        end
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
        level_reg <= level_next;
    end

    assign busy     = (state_reg != lpce_pkg::LN_IDLE);
    assign filtered = filt_reg;
    assign level    = level_reg;
endmodule

@@ rtl/lpce_merge.sv @@
// Merging stage: strength, weighted sum, centroid division and lost-line handling.
`timescale 1ns / 1ps
module lpce_merge (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           start,
    input  logic [lpce_pkg::NUM_CH-1:0][lpce_pkg::LEVEL_W-1:0] levels,
    input  logic [lpce_pkg::STRENGTH_W-1:0]                threshold,
    input  logic [lpce_pkg::STRENGTH_W-1:0]                lost_mag,
    output logic                                           busy,
    output logic [lpce_pkg::STRENGTH_W-1:0]                strength,
    output logic signed [lpce_pkg::ERROR_W-1:0]            position_error,
    output logic                                           line_lost
);
    localparam int SW = lpce_pkg::STRENGTH_W;
    localparam int WW = lpce_pkg::WEIGHT_W;
    localparam int QW = lpce_pkg::QUOT_W;
    localparam int EW = lpce_pkg::ERROR_W;

    lpce_pkg::merge_state_t state_reg, state_next;
    logic [SW-1:0] str_reg;
    logic          neg_reg, last_neg_reg, last_neg_next, lost_reg, lost_next;
    logic [WW-1:0] rem_reg, rem_next, trial;
    logic [QW-1:0] q_reg, q_next;
    logic [3:0]    bit_reg, bit_next;
    logic signed [EW-1:0] err_reg, err_next;

    logic [SW-1:0] str_sum;
    logic [WW-1:0] wpos, wneg;

    always_comb begin
        str_sum = SW'(levels[0]) + SW'(levels[1]) + SW'(levels[2]) + SW'(levels[3]);
        wneg = WW'(levels[0]) * WW'(lpce_pkg::WEIGHT_OUTER)
             + WW'(levels[1]) * WW'(lpce_pkg::WEIGHT_INNER);
        wpos = WW'(levels[3]) * WW'(lpce_pkg::WEIGHT_OUTER)
             + WW'(levels[2]) * WW'(lpce_pkg::WEIGHT_INNER);
    end

    assign trial = WW'(str_reg) << bit_reg;

    always_comb begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        bit_next      = bit_reg;
        err_next      = err_reg;
        lost_next     = lost_reg;
        last_neg_next = last_neg_reg;
        case (state_reg)
            lpce_pkg::MG_IDLE: begin
                if (start) begin
                    rem_next   = (wneg > wpos) ? wneg - wpos : wpos - wneg;
                    q_next     = '0;
                    bit_next   = 4'(QW - 1);
                    state_next = lpce_pkg::MG_DIV;
                end
            end
            lpce_pkg::MG_DIV: begin
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    q_next   = q_reg | (QW'(1) << bit_reg);
                end
                bit_next = bit_reg - 4'd1;
                if (bit_reg == 4'd0) begin
                    state_next = lpce_pkg::MG_FIN;
                end
            end
            lpce_pkg::MG_FIN: begin
                lost_next = (str_reg < threshold);
                if (str_reg < threshold) begin
                    err_next = last_neg_reg ? -$signed({1'b0, lost_mag})
                                            : $signed({1'b0, lost_mag});
                end else if (str_reg == '0) begin
                    // A zero strength gives a zero error, which counts as non-negative.
                    err_next      = '0;
                    last_neg_next = 1'b0;
                end else begin
                    err_next      = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
                    last_neg_next = neg_reg && (q_reg != '0);
                end
                state_next = lpce_pkg::MG_IDLE;
            end
            default: begin
                state_next = lpce_pkg::MG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lpce_pkg::MG_IDLE;
            last_neg_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_neg_reg <= last_neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == lpce_pkg::MG_IDLE && start) begin
            str_reg <= str_sum;
            neg_reg <= (wneg > wpos);
        end
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        bit_reg  <= bit_next;
        err_reg  <= err_next;
        lost_reg <= lost_next;
    end

    assign busy           = (state_reg != lpce_pkg::MG_IDLE);
    assign strength       = str_reg;
    assign position_error = err_reg;
    assign line_lost      = lost_reg;
endmodule

@@ rtl/line_position_centroid_estimator.sv @@
// Top level of the line position estimator: configuration, lanes, merge and output register.
//
//  channel  | handshake           | payload
//  s_       | s_valid / s_ready   | s_sample_0..3
//  m_       | m_valid / m_ready   | m_filtered_0..3, m_level_0..3, m_strength,
//           |                     | m_position_error, m_line_lost
//  cfg_     | cfg_we              | cfg_index, cfg_wdata
//
// From acceptance to the output register an item passes through the lanes and the merge:
// each lane runs a multiply, a compare and up to 10 restoring divide steps, and the
// merge stage runs a 12-step centroid divide. The next item is taken once the result
// has moved to the output register, while that result still waits for m_ready.
// Reset is synchronous and active low; it restores the calibration defaults and
// unprimes the filters. No clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module line_position_centroid_estimator #(
    parameter int SAMPLE_BITS  = lpce_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_SHIFT = lpce_pkg::FILTER_SHIFT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [4*SAMPLE_BITS-1:0]               cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [SAMPLE_BITS-1:0]                 s_sample_0,
    input  logic [SAMPLE_BITS-1:0]                 s_sample_1,
    input  logic [SAMPLE_BITS-1:0]                 s_sample_2,
    input  logic [SAMPLE_BITS-1:0]                 s_sample_3,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [SAMPLE_BITS-1:0]                 m_filtered_0,
    output logic [SAMPLE_BITS-1:0]                 m_filtered_1,
    output logic [SAMPLE_BITS-1:0]                 m_filtered_2,
    output logic [SAMPLE_BITS-1:0]                 m_filtered_3,
    output logic [lpce_pkg::LEVEL_W-1:0]           m_level_0,
    output logic [lpce_pkg::LEVEL_W-1:0]           m_level_1,
    output logic [lpce_pkg::LEVEL_W-1:0]           m_level_2,
    output logic [lpce_pkg::LEVEL_W-1:0]           m_level_3,
    output logic [lpce_pkg::STRENGTH_W-1:0]        m_strength,
    output logic signed [lpce_pkg::ERROR_W-1:0]    m_position_error,
    output logic                                   m_line_lost
);
    localparam int NC  = lpce_pkg::NUM_CH;
    localparam int CW  = NC * SAMPLE_BITS;
    localparam int LW  = lpce_pkg::LEVEL_W;

    lpce_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0] white_reg, black_reg;
    logic [lpce_pkg::STRENGTH_W-1:0] thr_reg, lmag_reg;
    logic primed_reg, primed_next;
    logic m_valid_reg, m_valid_next;

    logic [NC-1:0][SAMPLE_BITS-1:0] smp, filt, filt_out_reg;
    logic [NC-1:0][LW-1:0]          lvl, lvl_out_reg;
    logic [NC-1:0]                  lane_busy;
    logic [lpce_pkg::STRENGTH_W-1:0] mg_strength, str_out_reg;
    logic signed [lpce_pkg::ERROR_W-1:0] mg_err, err_out_reg;
    logic mg_lost, lost_out_reg, mg_busy, mg_start, accept, load;

    assign smp    = {s_sample_3, s_sample_2, s_sample_1, s_sample_0};
    assign s_ready = (state_reg == lpce_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    for (genvar i = 0; i < NC; i++) begin : g_lane
        lpce_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .FILTER_SHIFT(FILTER_SHIFT)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (accept),
            .primed  (primed_reg),
            .sample  (smp[i]),
            .white   (white_reg[i*SAMPLE_BITS +: SAMPLE_BITS]),
            .black   (black_reg[i*SAMPLE_BITS +: SAMPLE_BITS]),
            .busy    (lane_busy[i]),
            .filtered(filt[i]),
            .level   (lvl[i])
        );
    end

    lpce_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (mg_start),
        .levels        (lvl),
        .threshold     (thr_reg),
        .lost_mag      (lmag_reg),
        .busy          (mg_busy),
        .strength      (mg_strength),
        .position_error(mg_err),
        .line_lost     (mg_lost)
    );

    always_comb begin
        state_next = state_reg;
        mg_start   = 1'b0;
        load       = 1'b0;
        case (state_reg)
            lpce_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lpce_pkg::ST_LANES;
                end
            end
            lpce_pkg::ST_LANES: begin
                if (lane_busy == '0) begin
                    mg_start   = 1'b1;
                    state_next = lpce_pkg::ST_MERGE;
                end
            end
            lpce_pkg::ST_MERGE: begin
                if (!mg_busy) begin
                    state_next = lpce_pkg::ST_OUT;
                end
            end
            lpce_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load       = 1'b1;
                    state_next = lpce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpce_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        primed_next = primed_reg;
        if (accept) begin
            primed_next = 1'b1;
        end
        // Writing either calibration register restarts the filters from the next item.
        if (cfg_we && (lpce_pkg::cfg_reg_t'(cfg_index) == lpce_pkg::REG_WHITE ||
                       lpce_pkg::cfg_reg_t'(cfg_index) == lpce_pkg::REG_BLACK)) begin
            primed_next = 1'b0;
        end
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lpce_pkg::ST_IDLE;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            white_reg   <= lpce_pkg::WHITE_RST[CW-1:0];
            black_reg   <= lpce_pkg::BLACK_RST[CW-1:0];
            thr_reg     <= lpce_pkg::THRESH_RST;
            lmag_reg    <= lpce_pkg::LOST_MAG_RST;
        end else begin
            state_reg   <= state_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (lpce_pkg::cfg_reg_t'(cfg_index))
                    lpce_pkg::REG_WHITE:     white_reg <= cfg_wdata;
                    lpce_pkg::REG_BLACK:     black_reg <= cfg_wdata;
                    lpce_pkg::REG_THRESHOLD: thr_reg   <= cfg_wdata[lpce_pkg::STRENGTH_W-1:0];
                    lpce_pkg::REG_LOST_MAG:  lmag_reg  <= cfg_wdata[lpce_pkg::STRENGTH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            filt_out_reg <= filt;
            lvl_out_reg  <= lvl;
            str_out_reg  <= mg_strength;
            err_out_reg  <= mg_err;
            lost_out_reg <= mg_lost;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_0     = filt_out_reg[0];
    assign m_filtered_1     = filt_out_reg[1];
    assign m_filtered_2     = filt_out_reg[2];
    assign m_filtered_3     = filt_out_reg[3];
    assign m_level_0        = lvl_out_reg[0];
    assign m_level_1        = lvl_out_reg[1];
    assign m_level_2        = lvl_out_reg[2];
    assign m_level_3        = lvl_out_reg[3];
    assign m_strength       = str_out_reg;
    assign m_position_error = err_out_reg;
    assign m_line_lost      = lost_out_reg;

    `CHK_NEXT(a_lanes_start, aclk, aresetn, accept, lane_busy == {NC{1'b1}})
    `CHK_SAME(a_merge_after_lanes, aclk, aresetn, mg_start, lane_busy == '0 && !mg_busy)
    `CHK_NEXT(a_out_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)
    `CHK_SAME(a_level_range, aclk, aresetn, m_valid_reg, m_level_0 <= LW'(lpce_pkg::LEVEL_MAX))
endmodule

@@ tb/line_position_centroid_estimator_tb.sv @@
// Self-checking testbench for the line position centroid estimator.
`timescale 1ns / 1ps
module line_position_centroid_estimator_tb;
    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [11:0] s_sample_0, s_sample_1, s_sample_2, s_sample_3;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_filtered_0, m_filtered_1, m_filtered_2, m_filtered_3;
    logic [9:0]  m_level_0, m_level_1, m_level_2, m_level_3;
    logic [11:0] m_strength;
    logic signed [12:0] m_position_error;
    logic        m_line_lost;

    typedef struct packed {
        logic [3:0][11:0] filt;
        logic [3:0][9:0]  lvl;
        logic [11:0]      strength;
        logic [12:0]      err;
        logic             lost;
    } scan_result_t;

    line_position_centroid_estimator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample_0(s_sample_0), .s_sample_1(s_sample_1),
        .s_sample_2(s_sample_2), .s_sample_3(s_sample_3),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_filtered_0(m_filtered_0), .m_filtered_1(m_filtered_1),
        .m_filtered_2(m_filtered_2), .m_filtered_3(m_filtered_3),
        .m_level_0(m_level_0), .m_level_1(m_level_1),
        .m_level_2(m_level_2), .m_level_3(m_level_3),
        .m_strength(m_strength), .m_position_error(m_position_error),
        .m_line_lost(m_line_lost)
    );

    // Predictor state.
    logic [47:0] white_cal, black_cal;
    logic [11:0] lost_thresh, lost_mag;
    int          filt_acc [4];
    bit          primed;
    bit          last_neg;

    scan_result_t expected_scans [$];
    int  errors;
    int  send_idle_pct, recv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("line_position_centroid_estimator verification failed");
        $finish;
    end

    function automatic int floor_half(int d);
        if (d >= 0) return d >>> 1;
        return -((-d + 1) >>> 1);
    endfunction

    function automatic int norm_level(int v, int w, int b);
        longint span, q;
        span = b - w;
        if (span == 0) return 0;
        q = (longint'(v) - w) * 1000 / span;
        if (q < 0) q = 0;
        if (q > 1000) q = 1000;
        return int'(q);
    endfunction

    task automatic predict_scan(input logic [3:0][11:0] raw);
        scan_result_t r;
        int  wsum, st, e, f, lv;
        int  weights [4];
        weights = '{-3000, -1000, 1000, 3000};
        wsum = 0;
        st = 0;
        for (int i = 0; i < 4; i++) begin
            if (!primed) begin
                filt_acc[i] = int'(raw[i]) * 2;
                f = int'(raw[i]);
            end else begin
                filt_acc[i] += floor_half(int'(raw[i]) * 2 - filt_acc[i]);
                f = filt_acc[i] + 1;
                f = (f < 0) ? 0 : f >>> 1;
                if (f > 4095) f = 4095;
            end
            lv = norm_level(f, int'(white_cal[i*12 +: 12]), int'(black_cal[i*12 +: 12]));
            r.filt[i] = 12'(f);
            r.lvl[i] = 10'(lv);
            st += lv;
            wsum += lv * weights[i];
        end
        primed = 1'b1;
        r.strength = 12'(st);
        r.lost = (st < int'(lost_thresh));
        if (r.lost) begin
            e = last_neg ? -int'(lost_mag) : int'(lost_mag);
        end else begin
            e = (st == 0) ? 0 : wsum / st;
            last_neg = (e < 0);
        end
        r.err = 13'(e);
        expected_scans.push_back(r);
    endtask

    task automatic write_reg(input lpce_pkg::cfg_reg_t idx, input logic [47:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            lpce_pkg::REG_WHITE: begin white_cal = val; primed = 1'b0; end
            lpce_pkg::REG_BLACK: begin black_cal = val; primed = 1'b0; end
            lpce_pkg::REG_THRESHOLD: lost_thresh = val[11:0];
            lpce_pkg::REG_LOST_MAG: lost_mag = val[11:0];
            default: begin
            end
        endcase
    endtask

    // Valid drops only for idle cycles, so back-to-back items never see two drives at one edge.
    task automatic send_scan(input logic [3:0][11:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_0 <= raw[0];
        s_sample_1 <= raw[1];
        s_sample_2 <= raw[2];
        s_sample_3 <= raw[3];
        predict_scan(raw);
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every expected result is back, then let the block idle.
    task automatic drain;
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_scans.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        scan_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.filt = {m_filtered_3, m_filtered_2, m_filtered_1, m_filtered_0};
            got.lvl = {m_level_3, m_level_2, m_level_1, m_level_0};
            got.strength = m_strength;
            got.err = m_position_error;
            got.lost = m_line_lost;
            if (expected_scans.size() == 0) begin
                $display("%0t: unexpected item, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_scans.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.filt[i] !== want.filt[i]) begin
                        $display("%0t: filtered_%0d expected %0d actual %0d",
                                 $time, i, want.filt[i], got.filt[i]);
                        errors++;
                    end
                    if (got.lvl[i] !== want.lvl[i]) begin
                        $display("%0t: level_%0d expected %0d actual %0d",
                                 $time, i, want.lvl[i], got.lvl[i]);
                        errors++;
                    end
                end
                if (got.strength !== want.strength) begin
                    $display("%0t: strength expected %0d actual %0d",
                             $time, want.strength, got.strength);
                    errors++;
                end
                if (got.err !== want.err) begin
                    $display("%0t: position_error expected %0d actual %0d",
                             $time, $signed(want.err), $signed(got.err));
                    errors++;
                end
                if (got.lost !== want.lost) begin
                    $display("%0t: line_lost expected %0d actual %0d",
                             $time, want.lost, got.lost);
                    errors++;
                end
            end
        end
    end

    function automatic logic [3:0][11:0] rand_scan();
        logic [3:0][11:0] r;
        for (int i = 0; i < 4; i++) r[i] = 12'($urandom_range(4095));
        return r;
    endfunction

    // A dark blob around a random center, over a light floor.
    function automatic logic [3:0][11:0] line_scan();
        logic [3:0][11:0] r;
        int c, d;
        c = int'($urandom_range(6));
        for (int i = 0; i < 4; i++) begin
            d = (c > 2 * i) ? c - 2 * i : 2 * i - c;
            r[i] = (d <= 1) ? 12'($urandom_range(3400, 2000)) :
                   (d <= 3) ? 12'($urandom_range(2000, 800)) : 12'($urandom_range(500, 0));
        end
        return r;
    endfunction

    task automatic test_directed;
        send_scan({4{12'd0}});
        send_scan({4{12'hFFF}});
        send_scan({4{12'd0}});
        send_scan({12'd0, 12'd0, 12'd0, 12'hFFF});
        send_scan({12'hFFF, 12'd0, 12'd0, 12'd0});
        send_scan({12'd0, 12'd0, 12'hFFF, 12'd0});
        send_scan({12'hAAA, 12'h555, 12'hAAA, 12'h555});
        repeat (4) send_scan({4{12'd100}});
        drain();
        // Lost line with the sign taken from the last valid error.
        write_reg(lpce_pkg::REG_LOST_MAG, 48'd4000);
        send_scan({12'd3000, 12'd100, 12'd100, 12'd100});
        send_scan({4{12'd0}});
        send_scan({12'd100, 12'd100, 12'd100, 12'd3000});
        send_scan({4{12'd0}});
        drain();
        // Zero threshold with zero strength, and zero span.
        write_reg(lpce_pkg::REG_THRESHOLD, 48'd0);
        write_reg(lpce_pkg::REG_WHITE, {4{12'd1000}});
        write_reg(lpce_pkg::REG_BLACK, {12'd1000, 12'd1000, 12'd1000, 12'd1000});
        send_scan({4{12'd2000}});
        send_scan({4{12'd500}});
        drain();
        // Inverted span.
        write_reg(lpce_pkg::REG_WHITE, {4{12'd3500}});
        write_reg(lpce_pkg::REG_BLACK, {4{12'd200}});
        send_scan({4{12'd100}});
        send_scan({4{12'd3600}});
        send_scan({4{12'd1000}});
        drain();
    endtask

    task automatic test_random_phase(input int n, input int inv_pct);
        logic [47:0] w, b;
        for (int i = 0; i < 4; i++) begin
            w[i*12 +: 12] = 12'($urandom_range(600));
            b[i*12 +: 12] = 12'($urandom_range(4095, 1800));
            if ($urandom_range(99) < inv_pct) begin
                w[i*12 +: 12] = 12'($urandom_range(4095));
                b[i*12 +: 12] = 12'($urandom_range(4095));
            end
        end
        write_reg(lpce_pkg::REG_WHITE, w);
        write_reg(lpce_pkg::REG_BLACK, b);
        write_reg(lpce_pkg::REG_THRESHOLD, 48'($urandom_range(4000)));
        write_reg(lpce_pkg::REG_LOST_MAG, 48'($urandom_range(4000)));
        for (int k = 0; k < n; k++)
            send_scan(($urandom_range(99) < 75) ? line_scan() : rand_scan());
        drain();
    endtask

    task automatic test_extreme_config;
        write_reg(lpce_pkg::REG_WHITE, 48'h0);
        write_reg(lpce_pkg::REG_BLACK, 48'hFFFF_FFFF_FFFF);
        write_reg(lpce_pkg::REG_THRESHOLD, 48'd4000);
        write_reg(lpce_pkg::REG_LOST_MAG, 48'd0);
        for (int k = 0; k < 60; k++) send_scan(rand_scan());
        drain();
        write_reg(lpce_pkg::REG_WHITE, 48'hFFFF_FFFF_FFFF);
        write_reg(lpce_pkg::REG_BLACK, 48'h0);
        write_reg(lpce_pkg::REG_THRESHOLD, 48'd1);
        write_reg(lpce_pkg::REG_LOST_MAG, 48'd4000);
        for (int k = 0; k < 60; k++) send_scan(rand_scan());
        drain();
    endtask

    initial begin
        errors = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lpce_pkg::REG_WHITE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_sample_0 = '0;
        s_sample_1 = '0;
        s_sample_2 = '0;
        s_sample_3 = '0;
        m_ready = 1'b0;
        white_cal = lpce_pkg::WHITE_RST[47:0];
        black_cal = lpce_pkg::BLACK_RST[47:0];
        lost_thresh = lpce_pkg::THRESH_RST;
        lost_mag = lpce_pkg::LOST_MAG_RST;
        primed = 1'b0;
        last_neg = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 58;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        for (int p = 0; p < 6; p++) test_random_phase(105, 20);
        send_idle_pct = 58;
        recv_idle_pct = 27;
        test_extreme_config();
        for (int p = 0; p < 5; p++) test_random_phase(105, 20);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int p = 0; p < 6; p++) test_random_phase(105, 30);

        if (expected_scans.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, expected_scans.size());
            errors++;
        end
        if (errors == 0) begin
            $display("line_position_centroid_estimator verification clean");
        end else begin
            $display("line_position_centroid_estimator verification failed");
        end
        $finish;
    end
endmodule
